// ===== hdl/uce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and reset values for the endpoint-zero control engine.
// No dependencies; imported by every module of the block.
package uce_pkg;

    // Configuration reset values and buffer default
    localparam int        UCE_BUFFER_BYTES = 256;
    localparam logic [6:0] PKT_SIZE_RESET  = 7'd64;
    localparam logic [8:0] BUF_CAP_RESET   = 9'd248;
    localparam logic [6:0] SETUP_LEN       = 7'h08;
    localparam int        MAX_RES          = 4;

    // Configuration register indexes
    localparam logic CFG_PKT_SIZE = 1'b0;
    localparam logic CFG_BUF_CAP  = 1'b1;

    // Event kinds
    localparam logic [1:0] KIND_BUS_RESET = 2'd0;
    localparam logic [1:0] KIND_SETUP     = 2'd1;
    localparam logic [1:0] KIND_OUT       = 2'd2;
    localparam logic [1:0] KIND_IN_SENT   = 2'd3;

    // Result actions
    localparam logic [3:0] ACT_NONE        = 4'd0;
    localparam logic [3:0] ACT_STORE_OUT   = 4'd1;
    localparam logic [3:0] ACT_WRITE_REPLY = 4'd2;
    localparam logic [3:0] ACT_SEND_IN     = 4'd3;
    localparam logic [3:0] ACT_STALL_EP0   = 4'd4;
    localparam logic [3:0] ACT_SET_HALT    = 4'd5;
    localparam logic [3:0] ACT_CLEAR_HALT  = 4'd6;
    localparam logic [3:0] ACT_DECONFIGURE = 4'd7;
    localparam logic [3:0] ACT_CONFIGURE   = 4'd8;
    localparam logic [3:0] ACT_SET_ADDRESS = 4'd9;
    localparam logic [3:0] ACT_COMPLETE    = 4'd10;
    localparam logic [3:0] ACT_RESET_EP0   = 4'd11;

    // Control stages
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DOUT = 3'd1;
    localparam logic [2:0] ST_DIN  = 3'd2;
    localparam logic [2:0] ST_DINZ = 3'd3;
    localparam logic [2:0] ST_LAST = 3'd4;
    localparam logic [2:0] ST_SIN  = 3'd5;
    localparam logic [2:0] ST_SOUT = 3'd6;

    // Device states
    localparam logic [1:0] DEV_DEFAULT    = 2'd0;
    localparam logic [1:0] DEV_ADDRESSED  = 2'd1;
    localparam logic [1:0] DEV_CONFIGURED = 2'd2;

    // Handler verdicts
    localparam logic [1:0] VERD_FAIL = 2'd0;
    localparam logic [1:0] VERD_ACK  = 2'd1;
    localparam logic [1:0] VERD_NAK  = 2'd2;

    // Request recipients (type bits with direction masked off)
    localparam logic [6:0] RCPT_DEVICE    = 7'h00;
    localparam logic [6:0] RCPT_INTERFACE = 7'h01;
    localparam logic [6:0] RCPT_ENDPOINT  = 7'h02;

    // Standard request codes
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    typedef struct packed {
        logic [2:0]  stage;
        logic [1:0]  dev_state;
        logic [7:0]  active_config;
        logic [8:0]  cursor;
        logic [15:0] remaining;
        logic        address_pending;
        logic [6:0]  new_address;
        logic [7:0]  saved_type;
        logic [15:0] saved_length;
    } ctx_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  pkt_len;
        logic [7:0]  req_type;
        logic [7:0]  request_code;
        logic [15:0] req_value;
        logic [15:0] req_index;
        logic [15:0] req_length;
        logic [1:0]  app_verdict;
        logic        helper_ok;
        logic [15:0] reply_len;
        logic        ep_stalled;
    } item_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [8:0]  buf_offset;
        logic [15:0] byte_count;
        logic [15:0] reply_bytes;
        logic [15:0] target;
    } res_t;

    typedef struct packed {
        logic [2:0]              count;
        logic [1:0]              dev_state;
        res_t [MAX_RES-1:0]      slot;
    } bundle_t;

    function automatic res_t mk_res(input logic [3:0] act, input logic [8:0] off,
                                    input logic [15:0] cnt, input logic [15:0] rep,
                                    input logic [15:0] tgt);
        res_t r;
        r.action      = act;
        r.buf_offset  = off;
        r.byte_count  = cnt;
        r.reply_bytes = rep;
        r.target      = tgt;
        return r;
    endfunction

endpackage

// ===== hdl/uce_core.sv =====
`timescale 1ns / 1ps
// Event decoder of the control engine: next context and the result bundle
// for one event. Pure combinational; depends on uce_pkg.
module uce_core
    import uce_pkg::*;
#(
    parameter int BUFFER_BYTES = UCE_BUFFER_BYTES
)
(
    input  ctx_t       ctx,
    input  item_t      item,
    input  logic [6:0] pkt_size,
    input  logic [8:0] buf_cap,
    output ctx_t       ctx_next,
    output bundle_t    bundle
);

    localparam int CAP_LIMIT = (BUFFER_BYTES > 8) ? (BUFFER_BYTES - 8) : 0;

    logic [15:0] cap;

    always_comb
    begin
        if ({7'd0, buf_cap} < 16'(CAP_LIMIT))
            cap = {7'd0, buf_cap};
        else
            cap = 16'(CAP_LIMIT);
    end

    always_comb
    begin
        ctx_t              c;
        res_t [MAX_RES-1:0] r;
        logic [2:0]        n;
        logic [1:0]        verdict;
        logic              do_process;
        logic              do_tx;
        logic              do_finish;
        logic [15:0]       t;
        logic [15:0]       len;
        logic [15:0]       psize;

        c          = ctx;
        r          = '0;
        n          = 3'd0;
        verdict    = VERD_FAIL;
        do_process = 1'b0;
        do_tx      = 1'b0;
        do_finish  = 1'b0;
        t          = 16'd0;
        len        = {9'd0, item.pkt_len};
        psize      = {9'd0, pkt_size};

        case (item.kind)
            KIND_BUS_RESET:
            begin
                c.dev_state       = DEV_DEFAULT;
                c.stage           = ST_IDLE;
                c.active_config   = 8'd0;
                c.address_pending = 1'b0;
                r[0] = mk_res(ACT_RESET_EP0, 9'd0, psize, 16'd0, 16'd0);
                r[1] = mk_res(ACT_SET_ADDRESS, 9'd0, 16'd0, 16'd0, 16'd0);
                n    = 3'd2;
            end
            KIND_SETUP, KIND_OUT:
            begin
                if (item.kind == KIND_SETUP)
                begin
                    c.stage           = ST_IDLE;
                    c.address_pending = 1'b0;
                end
                case (c.stage)
                    ST_IDLE:
                    begin
                        if (item.pkt_len != SETUP_LEN)
                        begin
                            r[n[1:0]] = mk_res(ACT_STALL_EP0, 9'd0, 16'd0, 16'd0, 16'd0);
                            n         = n + 3'd1;
                            c.stage   = ST_IDLE;
                        end
                        else
                        begin
                            c.saved_type   = item.req_type;
                            c.saved_length = item.req_length;
                            c.cursor       = 9'd0;
                            c.remaining    = item.req_length;
                            if (item.req_type[7] || item.req_length == 16'd0)
                                do_process = 1'b1;
                            else if (item.req_length > cap)
                            begin
                                r[n[1:0]] = mk_res(ACT_STALL_EP0, 9'd0, 16'd0, 16'd0,
                                                   16'd0);
                                n         = n + 3'd1;
                                c.stage   = ST_IDLE;
                            end
                            else
                                c.stage = ST_DOUT;
                        end
                    end
                    ST_DOUT:
                    begin
                        if (c.remaining < len)
                        begin
                            r[n[1:0]] = mk_res(ACT_STALL_EP0, 9'd0, 16'd0, 16'd0, 16'd0);
                            n         = n + 3'd1;
                            c.stage   = ST_IDLE;
                        end
                        else
                        begin
                            r[n[1:0]] = mk_res(ACT_STORE_OUT, c.cursor, len, 16'd0, 16'd0);
                            n         = n + 3'd1;
                            if (c.remaining != len)
                            begin
                                c.remaining = c.remaining - len;
                                c.cursor    = c.cursor + {2'd0, item.pkt_len};
                            end
                            else
                                do_process = 1'b1;
                        end
                    end
                    ST_SOUT:
                    begin
                        // status-out payload is dropped
                        c.stage   = ST_IDLE;
                        do_finish = 1'b1;
                    end
                    default:
                    begin
                        r[n[1:0]] = mk_res(ACT_STALL_EP0, 9'd0, 16'd0, 16'd0, 16'd0);
                        n         = n + 3'd1;
                        c.stage   = ST_IDLE;
                    end
                endcase
            end
            default:
                do_tx = 1'b1;
        endcase

        // Decide the request: handler verdict first, standard requests otherwise
        if (do_process)
        begin
            verdict     = item.app_verdict;
            c.cursor    = 9'd0;
            c.remaining = c.saved_length;
            if (verdict == VERD_ACK)
                c.remaining = item.reply_len;
            else if (verdict != VERD_NAK)
            begin
                verdict = VERD_FAIL;
                case (c.saved_type[6:0])
                    RCPT_DEVICE:
                    begin
                        case (item.request_code)
                            REQ_GET_STATUS:
                            begin
                                r[n[1:0]] = mk_res(ACT_WRITE_REPLY, 9'd0, 16'd0, 16'd0,
                                                   16'd0);
                                n         = n + 3'd1;
                                verdict   = VERD_ACK;
                            end
                            REQ_SET_ADDRESS:
                            begin
                                c.address_pending = 1'b1;
                                c.new_address     = item.req_value[6:0];
                                verdict           = VERD_ACK;
                            end
                            REQ_GET_DESCRIPTOR:
                            begin
                                if (item.helper_ok)
                                begin
                                    c.remaining = item.reply_len;
                                    verdict     = VERD_ACK;
                                end
                            end
                            REQ_GET_CONFIG:
                            begin
                                r[n[1:0]] = mk_res(ACT_WRITE_REPLY, 9'd0, 16'd0,
                                                   {8'd0, c.active_config}, 16'd0);
                                n         = n + 3'd1;
                                verdict   = VERD_ACK;
                            end
                            REQ_SET_CONFIG:
                            begin
                                if (item.req_value[7:0] == 8'd0)
                                begin
                                    r[n[1:0]] = mk_res(ACT_DECONFIGURE, 9'd0, 16'd0, 16'd0,
                                                       16'd0);
                                    n               = n + 3'd1;
                                    c.active_config = 8'd0;
                                    c.dev_state     = DEV_ADDRESSED;
                                    verdict         = VERD_ACK;
                                end
                                else if (item.helper_ok)
                                begin
                                    r[n[1:0]] = mk_res(ACT_CONFIGURE, 9'd0, 16'd0, 16'd0,
                                                       {8'd0, item.req_value[7:0]});
                                    n               = n + 3'd1;
                                    c.active_config = item.req_value[7:0];
                                    c.dev_state     = DEV_CONFIGURED;
                                    verdict         = VERD_ACK;
                                end
                            end
                            default:
                                verdict = VERD_FAIL;
                        endcase
                    end
                    RCPT_INTERFACE:
                    begin
                        if (item.request_code == REQ_GET_STATUS)
                        begin
                            r[n[1:0]] = mk_res(ACT_WRITE_REPLY, 9'd0, 16'd0, 16'd0, 16'd0);
                            n         = n + 3'd1;
                            verdict   = VERD_ACK;
                        end
                    end
                    RCPT_ENDPOINT:
                    begin
                        verdict = VERD_ACK;
                        if (item.request_code == REQ_SET_FEATURE)
                        begin
                            r[n[1:0]] = mk_res(ACT_SET_HALT, 9'd0, 16'd0, 16'd0,
                                               item.req_index);
                            n         = n + 3'd1;
                        end
                        else if (item.request_code == REQ_CLEAR_FEATURE)
                        begin
                            r[n[1:0]] = mk_res(ACT_CLEAR_HALT, 9'd0, 16'd0, 16'd0,
                                               item.req_index);
                            n         = n + 3'd1;
                        end
                        else if (item.request_code == REQ_GET_STATUS)
                        begin
                            r[n[1:0]] = mk_res(ACT_WRITE_REPLY, 9'd0, 16'd0,
                                               {15'd0, item.ep_stalled}, 16'd0);
                            n         = n + 3'd1;
                        end
                    end
                    default:
                        verdict = VERD_FAIL;
                endcase
            end

            if (verdict == VERD_ACK)
            begin
                if (c.saved_type[7])
                begin
                    // short reply needs a zero-length packet to end the data stage
                    if (c.remaining >= c.saved_length)
                    begin
                        c.remaining = c.saved_length;
                        c.stage     = ST_DIN;
                    end
                    else
                        c.stage = ST_DINZ;
                    do_tx = 1'b1;
                end
                else
                begin
                    c.stage   = ST_SIN;
                    r[n[1:0]] = mk_res(ACT_SEND_IN, 9'd0, 16'd0, 16'd0, 16'd0);
                    n         = n + 3'd1;
                end
            end
            else if (verdict == VERD_NAK)
                c.stage = ST_SIN;
            else
            begin
                r[n[1:0]] = mk_res(ACT_STALL_EP0, 9'd0, 16'd0, 16'd0, 16'd0);
                n         = n + 3'd1;
                c.stage   = ST_IDLE;
            end
        end

        if (do_tx)
        begin
            case (c.stage)
                ST_DIN, ST_DINZ:
                begin
                    t         = (c.remaining < psize) ? c.remaining : psize;
                    r[n[1:0]] = mk_res(ACT_SEND_IN, c.cursor, t, 16'd0, 16'd0);
                    n         = n + 3'd1;
                    c.cursor    = c.cursor + t[8:0];
                    c.remaining = c.remaining - t;
                    if (c.remaining == 16'd0 && (c.stage == ST_DIN || t != psize))
                        c.stage = ST_LAST;
                end
                ST_LAST:
                    c.stage = ST_SOUT;
                ST_SIN:
                begin
                    c.stage   = ST_IDLE;
                    do_finish = 1'b1;
                end
                default:
                    c.stage = c.stage;
            endcase
        end

        if (do_finish)
        begin
            if (c.address_pending)
            begin
                r[n[1:0]] = mk_res(ACT_SET_ADDRESS, 9'd0, 16'd0, 16'd0,
                                   {9'd0, c.new_address});
                n                 = n + 3'd1;
                c.dev_state       = (c.new_address != 7'd0) ? DEV_ADDRESSED : DEV_DEFAULT;
                c.address_pending = 1'b0;
            end
            else
            begin
                r[n[1:0]] = mk_res(ACT_COMPLETE, 9'd0, 16'd0, 16'd0, 16'd0);
                n         = n + 3'd1;
            end
        end

        ctx_next         = c;
        bundle.count     = n;
        bundle.dev_state = c.dev_state;
        bundle.slot      = r;
    end

endmodule

// ===== hdl/usb_control_endpoint_engine.sv =====
`timescale 1ns / 1ps
// USB endpoint-zero control transfer engine, top level.
// Instantiates uce_core; depends on uce_pkg.
//
// Usage: each event (bus reset, SETUP, OUT received, IN sent) enters as one
// beat on the s_ channel, kind in s_tuser and the decoded setup fields plus
// handler verdicts in s_tdata. Each event yields zero to three action beats
// on the m_ channel; m_tlast marks the final action of an event. The cfg_
// channel writes the packet size (index 0) and buffer capacity (index 1);
// it is always ready; the user must write it only while the engine is idle,
// which the block does not enforce. An accepted event waits in the input
// register; its decoded actions load into the result register behind m_.
// Throughput: one event per cycle while each event has at most one action
// and m_tready stays high; an event with N actions holds the decoder for N
// output beats, since the result register drains one action per beat.
// Reset clears the control context, empties both registers and restores
// the configuration defaults (packet size 64, capacity 248).
// A stall on m_tready holds the current action; the input register still
// takes one more event, and s_tready falls until the bundle drains.
module usb_control_endpoint_engine
    import uce_pkg::*;
#(
    parameter int BUFFER_BYTES = UCE_BUFFER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pkt_len, req_type, request_code, req_value, req_index, req_length,
    // app_verdict, helper_ok, reply_len, ep_stalled, zero fill
    input  logic [95:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // buf_offset, byte_count, reply_bytes, target, dev_state, zero fill
    output logic [63:0] m_tdata,
    // action
    output logic [3:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [6:0] pkt_size_reg;
    logic [8:0] buf_cap_reg;

    logic       in_valid_reg;
    item_t      in_item_reg;
    item_t      s_item;

    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    bundle_t    bundle_next;
    bundle_t    bundle_reg;
    logic [1:0] idx_reg;

    logic       out_take;
    logic       last_slot;
    logic       fire;
    res_t       cur;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_size_reg <= PKT_SIZE_RESET;
            buf_cap_reg  <= BUF_CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PKT_SIZE: pkt_size_reg <= cfg_data[6:0];
                CFG_BUF_CAP:  buf_cap_reg  <= cfg_data;
                default:      pkt_size_reg <= pkt_size_reg;
            endcase
        end
    end

    always_comb
    begin
        s_item.kind         = s_tuser;
        s_item.pkt_len      = s_tdata[6:0];
        s_item.req_type     = s_tdata[14:7];
        s_item.request_code = s_tdata[22:15];
        s_item.req_value    = s_tdata[38:23];
        s_item.req_index    = s_tdata[54:39];
        s_item.req_length   = s_tdata[70:55];
        s_item.app_verdict  = s_tdata[72:71];
        s_item.helper_ok    = s_tdata[73];
        s_item.reply_len    = s_tdata[89:74];
        s_item.ep_stalled   = s_tdata[90];
    end

    assign m_tvalid  = (bundle_reg.count != 3'd0);
    assign out_take  = m_tvalid && m_tready;
    assign last_slot = ({1'b0, idx_reg} == (bundle_reg.count - 3'd1));
    // decode when the result register is empty or its last beat leaves now
    assign fire      = in_valid_reg && (!m_tvalid || (out_take && last_slot));
    assign s_tready  = !in_valid_reg || fire;

    uce_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .ctx      (ctx_reg),
        .item     (in_item_reg),
        .pkt_size (pkt_size_reg),
        .buf_cap  (buf_cap_reg),
        .ctx_next (ctx_next),
        .bundle   (bundle_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg    <= '0;
            bundle_reg <= '0;
            idx_reg    <= 2'd0;
        end
        else if (fire)
        begin
            ctx_reg    <= ctx_next;
            bundle_reg <= bundle_next;
            idx_reg    <= 2'd0;
        end
        else if (out_take)
        begin
            if (last_slot)
                bundle_reg.count <= 3'd0;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    assign cur     = bundle_reg.slot[idx_reg];
    assign m_tuser = cur.action;
    assign m_tlast = last_slot;
    assign m_tdata = {5'd0, bundle_reg.dev_state, cur.target, cur.reply_bytes,
                      cur.byte_count, cur.buf_offset};

endmodule

// ===== hdl/uce_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the control engine, bound to the top level.
// Depends on uce_pkg and usb_control_endpoint_engine.
module uce_checker
    import uce_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // a held beat keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                    $stable(m_tuser) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

    // the rest of an event's actions follow without a gap
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside an event's actions");

    // bus reset answers with reset ep0 then set address to zero
    a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser == ACT_RESET_EP0) |=>
            (m_tvalid && m_tuser == ACT_SET_ADDRESS && m_tlast &&
             m_tdata[56:41] == 16'd0 && m_tdata[58:57] == DEV_DEFAULT))
        else $error("bus reset sequence broken");

    // input backpressure only while actions are waiting
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending output");

endmodule

bind usb_control_endpoint_engine uce_checker u_uce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/usb_control_endpoint_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the endpoint-zero control engine: directed transfers, then random
// control traffic across several register settings, checked against a built-in predictor.
// Depends on uce_pkg and usb_control_endpoint_engine.
module usb_control_endpoint_engine_test;
    import uce_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [3:0]  action;
        logic [8:0]  buf_offset;
        logic [15:0] byte_count;
        logic [15:0] reply_bytes;
        logic [15:0] target;
        logic [1:0]  dev_state;
        logic        last;
    } ep0_action_t;

    // Tracks the control transfer state and holds the actions still owed by the engine.
    class ep0_transfer_tracker;
        logic [6:0]  pkt_size      = PKT_SIZE_RESET;
        logic [8:0]  buf_cap       = BUF_CAP_RESET;
        logic [2:0]  stage         = ST_IDLE;
        logic [1:0]  dev_state     = DEV_DEFAULT;
        logic [7:0]  active_config = '0;
        logic [8:0]  cursor        = '0;
        logic [15:0] remaining     = '0;
        logic        addr_pending  = 1'b0;
        logic [6:0]  new_address   = '0;
        logic [7:0]  saved_type    = '0;
        logic [15:0] saved_length  = '0;
        ep0_action_t actions_due[$];
        ep0_action_t batch[$];
        int          mismatches    = 0;

        function void set_register(logic idx, logic [8:0] val);
            if (idx == CFG_PKT_SIZE)
                pkt_size = val[6:0];
            else
                buf_cap = val;
        endfunction

        function int pending();
            return actions_due.size();
        endfunction

        function void push(logic [3:0] act, logic [8:0] off, logic [15:0] cnt,
                           logic [15:0] rep, logic [15:0] tgt);
            ep0_action_t a;
            a = '0;
            a.action      = act;
            a.buf_offset  = off;
            a.byte_count  = cnt;
            a.reply_bytes = rep;
            a.target      = tgt;
            if (batch.size() < MAX_RES)
                batch.push_back(a);
        endfunction

        function logic [15:0] payload_room();
            logic [15:0] lim;
            lim = 16'(UCE_BUFFER_BYTES - 8);
            return (16'(buf_cap) < lim) ? 16'(buf_cap) : lim;
        endfunction

        function void stall_ep0();
            push(ACT_STALL_EP0, 0, 0, 0, 0);
            stage = ST_IDLE;
        endfunction

        function void finish_status();
            if (addr_pending)
            begin
                push(ACT_SET_ADDRESS, 0, 0, 0, 16'(new_address));
                dev_state    = (new_address != 0) ? DEV_ADDRESSED : DEV_DEFAULT;
                addr_pending = 1'b0;
            end
            else
                push(ACT_COMPLETE, 0, 0, 0, 0);
        endfunction

        function void in_sent();
            logic [15:0] t;
            case (stage)
                ST_DIN, ST_DINZ:
                begin
                    t = (remaining < 16'(pkt_size)) ? remaining : 16'(pkt_size);
                    push(ACT_SEND_IN, cursor, t, 0, 0);
                    cursor    = 9'(cursor + t);
                    remaining = remaining - t;
                    // a full last packet in the zlp stage still owes a zero-length one
                    if (remaining == 0 && (stage == ST_DIN || t != 16'(pkt_size)))
                        stage = ST_LAST;
                end
                ST_LAST:
                    stage = ST_SOUT;
                ST_SIN:
                begin
                    stage = ST_IDLE;
                    finish_status();
                end
                default:
                    ;
            endcase
        endfunction

        function logic [1:0] standard_request(item_t it);
            logic [1:0] v;
            logic [7:0] cfg;
            v   = VERD_FAIL;
            cfg = it.req_value[7:0];
            case (saved_type[6:0])
                RCPT_DEVICE:
                    case (it.request_code)
                        REQ_GET_STATUS:
                        begin
                            push(ACT_WRITE_REPLY, 0, 0, 0, 0);
                            v = VERD_ACK;
                        end
                        REQ_SET_ADDRESS:
                        begin
                            addr_pending = 1'b1;
                            new_address  = it.req_value[6:0];
                            v = VERD_ACK;
                        end
                        REQ_GET_DESCRIPTOR:
                            if (it.helper_ok)
                            begin
                                remaining = it.reply_len;
                                v = VERD_ACK;
                            end
                        REQ_GET_CONFIG:
                        begin
                            push(ACT_WRITE_REPLY, 0, 0, 16'(active_config), 0);
                            v = VERD_ACK;
                        end
                        REQ_SET_CONFIG:
                            if (cfg == 0)
                            begin
                                push(ACT_DECONFIGURE, 0, 0, 0, 0);
                                active_config = '0;
                                dev_state     = DEV_ADDRESSED;
                                v = VERD_ACK;
                            end
                            else if (it.helper_ok)
                            begin
                                push(ACT_CONFIGURE, 0, 0, 0, 16'(cfg));
                                active_config = cfg;
                                dev_state     = DEV_CONFIGURED;
                                v = VERD_ACK;
                            end
                        default:
                            ;
                    endcase
                RCPT_INTERFACE:
                    if (it.request_code == REQ_GET_STATUS)
                    begin
                        push(ACT_WRITE_REPLY, 0, 0, 0, 0);
                        v = VERD_ACK;
                    end
                RCPT_ENDPOINT:
                begin
                    // any other endpoint request is acked without an action
                    if (it.request_code == REQ_SET_FEATURE)
                        push(ACT_SET_HALT, 0, 0, 0, it.req_index);
                    else if (it.request_code == REQ_CLEAR_FEATURE)
                        push(ACT_CLEAR_HALT, 0, 0, 0, it.req_index);
                    else if (it.request_code == REQ_GET_STATUS)
                        push(ACT_WRITE_REPLY, 0, 0, 16'(it.ep_stalled), 0);
                    v = VERD_ACK;
                end
                default:
                    ;
            endcase
            return v;
        endfunction

        function void decide(item_t it);
            logic [1:0] v;
            v         = it.app_verdict;
            cursor    = '0;
            remaining = saved_length;
            if (v == VERD_ACK)
                remaining = it.reply_len;
            else if (v != VERD_NAK)
                v = standard_request(it);

            if (v == VERD_ACK)
            begin
                if (saved_type[7])
                begin
                    if (remaining >= saved_length)
                    begin
                        remaining = saved_length;
                        stage = ST_DIN;
                    end
                    else
                        stage = ST_DINZ;
                    in_sent();
                end
                else
                begin
                    stage = ST_SIN;
                    push(ACT_SEND_IN, 0, 0, 0, 0);
                end
            end
            else if (v == VERD_NAK)
                stage = ST_SIN;
            else
                stall_ep0();
        endfunction

        function void receive(item_t it);
            logic [15:0] len;
            len = 16'(it.pkt_len);
            case (stage)
                ST_IDLE:
                    if (it.pkt_len != SETUP_LEN)
                        stall_ep0();
                    else
                    begin
                        saved_type   = it.req_type;
                        saved_length = it.req_length;
                        cursor       = '0;
                        remaining    = saved_length;
                        if (saved_type[7] || saved_length == 0)
                            decide(it);
                        else if (saved_length > payload_room())
                            stall_ep0();
                        else
                            stage = ST_DOUT;
                    end
                ST_DOUT:
                    if (remaining < len)
                        stall_ep0();
                    else
                    begin
                        push(ACT_STORE_OUT, cursor, len, 0, 0);
                        if (remaining != len)
                        begin
                            remaining = remaining - len;
                            cursor    = 9'(cursor + len);
                        end
                        else
                            decide(it);
                    end
                ST_SOUT:
                begin
                    // status payload is dropped
                    stage = ST_IDLE;
                    finish_status();
                end
                default:
                    stall_ep0();
            endcase
        endfunction

        function void note_event(item_t it);
            batch.delete();
            case (it.kind)
                KIND_BUS_RESET:
                begin
                    dev_state     = DEV_DEFAULT;
                    stage         = ST_IDLE;
                    active_config = '0;
                    addr_pending  = 1'b0;
                    push(ACT_RESET_EP0, 0, 16'(pkt_size), 0, 0);
                    push(ACT_SET_ADDRESS, 0, 0, 0, 0);
                end
                KIND_SETUP:
                begin
                    stage        = ST_IDLE;
                    addr_pending = 1'b0;
                    receive(it);
                end
                KIND_OUT:
                    receive(it);
                default:
                    in_sent();
            endcase
            foreach (batch[k])
            begin
                batch[k].dev_state = dev_state;
                batch[k].last      = (k == batch.size() - 1);
                actions_due.push_back(batch[k]);
            end
        endfunction

        function string describe(ep0_action_t a);
            return $sformatf("act=%0d off=%0d cnt=%0d rep=%h tgt=%h dev=%0d last=%0d",
                             a.action, a.buf_offset, a.byte_count, a.reply_bytes,
                             a.target, a.dev_state, a.last);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void check_action(ep0_action_t got);
            ep0_action_t want;
            if (actions_due.size() == 0)
            begin
                flag({"unexpected beat ", describe(got)});
                return;
            end
            want = actions_due.pop_front();
            if (got.action != want.action || got.buf_offset != want.buf_offset ||
                got.byte_count != want.byte_count || got.reply_bytes != want.reply_bytes ||
                got.target != want.target || got.dev_state != want.dev_state ||
                got.last != want.last)
                flag({"expected ", describe(want), " got ", describe(got)});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    ep0_transfer_tracker sb;
    item_t               cur_event;
    bit                  burst;
    int                  out_hold;

    usb_control_endpoint_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample every handshake on the rising edge.
    always @(posedge clk)
    begin
        ep0_action_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_event(cur_event);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
            begin
                got.action      = m_tuser;
                got.buf_offset  = m_tdata[8:0];
                got.byte_count  = m_tdata[24:9];
                got.reply_bytes = m_tdata[40:25];
                got.target      = m_tdata[56:41];
                got.dev_state   = m_tdata[58:57];
                got.last        = m_tlast;
                sb.check_action(got);
                out_hold = burst ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // Receiver side: hold off for the drawn number of cycles after each beat.
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            m_tready = 1'b0;
            out_hold--;
        end
        else
            m_tready = 1'b1;
    end

    function automatic item_t control_event(logic [1:0] knd, logic [6:0] len,
                                            logic [7:0] rtype, logic [7:0] code,
                                            logic [15:0] wvalue, logic [15:0] windex,
                                            logic [15:0] wlength, logic [1:0] verdict,
                                            logic ok, logic [15:0] rlen, logic halted);
        item_t it;
        it.kind         = knd;
        it.pkt_len      = len;
        it.req_type     = rtype;
        it.request_code = code;
        it.req_value    = wvalue;
        it.req_index    = windex;
        it.req_length   = wlength;
        it.app_verdict  = verdict;
        it.helper_ok    = ok;
        it.reply_len    = rlen;
        it.ep_stalled   = halted;
        return it;
    endfunction

    function automatic item_t random_setup();
        item_t      it;
        logic [7:0] dir;
        logic [6:0] rcpt;
        int         roll;
        it = '0;
        // an OUT in idle is taken as a setup packet too
        it.kind    = ($urandom_range(0, 7) == 0) ? KIND_OUT : KIND_SETUP;
        it.pkt_len = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 64)) : SETUP_LEN;
        dir = $urandom_range(0, 1) ? 8'h80 : 8'h00;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: rcpt = RCPT_DEVICE;
            4, 5:       rcpt = RCPT_INTERFACE;
            6, 7:       rcpt = RCPT_ENDPOINT;
            default:    rcpt = 7'($urandom_range(0, 127));
        endcase
        it.req_type = dir | {1'b0, rcpt};
        case ($urandom_range(0, 9))
            0:       it.request_code = REQ_GET_STATUS;
            1:       it.request_code = REQ_CLEAR_FEATURE;
            2:       it.request_code = REQ_SET_FEATURE;
            3:       it.request_code = REQ_SET_ADDRESS;
            4:       it.request_code = REQ_GET_DESCRIPTOR;
            5:       it.request_code = REQ_GET_CONFIG;
            6, 7:    it.request_code = REQ_SET_CONFIG;
            default: it.request_code = 8'($urandom);
        endcase
        it.req_value = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        it.req_index = 16'($urandom);
        roll = $urandom_range(0, 9);
        it.req_length = (roll < 7) ? 16'($urandom_range(0, 80)) :
                        (roll < 9) ? 16'($urandom_range(0, 300)) : 16'($urandom);
        roll = $urandom_range(0, 9);
        it.app_verdict = (roll < 6) ? VERD_FAIL : (roll < 8) ? VERD_ACK : VERD_NAK;
        it.helper_ok   = 1'($urandom_range(0, 1));
        it.reply_len   = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 300))
                                                    : 16'($urandom);
        it.ep_stalled  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Mostly the event the transfer expects next, with noise and aborts mixed in.
    function automatic item_t random_event();
        item_t       it;
        int          pick;
        logic [15:0] room;
        it.kind         = 2'($urandom_range(0, 3));
        it.pkt_len      = 7'($urandom_range(0, 64));
        it.req_type     = 8'($urandom);
        it.request_code = 8'($urandom);
        it.req_value    = 16'($urandom);
        it.req_index    = 16'($urandom);
        it.req_length   = 16'($urandom);
        it.app_verdict  = 2'($urandom_range(0, 2));
        it.helper_ok    = 1'($urandom_range(0, 1));
        it.reply_len    = 16'($urandom);
        it.ep_stalled   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return it;
        if (pick < 15)
        begin
            it.kind = KIND_BUS_RESET;
            return it;
        end
        case (sb.stage)
            ST_DOUT:
            begin
                it.kind = KIND_OUT;
                room = (sb.remaining < 16'd64) ? sb.remaining : 16'd64;
                if (pick >= 25)
                    it.pkt_len = $urandom_range(0, 1) ? 7'(room)
                                                      : 7'($urandom_range(0, room));
            end
            ST_DIN, ST_DINZ:
                if (pick < 25 || (sb.remaining > 16'd256 && $urandom_range(0, 1)))
                    it = random_setup();
                else
                    it.kind = KIND_IN_SENT;
            ST_LAST, ST_SIN:
                it.kind = KIND_IN_SENT;
            ST_SOUT:
                it.kind = KIND_OUT;
            default:
                it = random_setup();
        endcase
        return it;
    endfunction

    task automatic send_event(item_t it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_event = it;
        s_tdata   = {5'b0, it.ep_stalled, it.reply_len, it.helper_ok, it.app_verdict,
                     it.req_length, it.req_index, it.req_value, it.request_code,
                     it.req_type, it.pkt_len};
        s_tuser   = it.kind;
        s_tvalid  = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0)
            @(negedge clk);
    endtask

    task automatic program_reg(logic idx, logic [8:0] val);
        wait_drained();
        // events with no action may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(logic [8:0] pkt, logic [8:0] cap, int count);
        int    done;
        item_t it;
        program_reg(CFG_PKT_SIZE, pkt);
        program_reg(CFG_BUF_CAP, cap);
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 19) == 0)
                burst = !burst;
            it = random_event();
            // an IN completion outside a data-in or status-in stage is ignored
            if (it.kind != KIND_IN_SENT || (sb.stage inside {ST_DIN, ST_DINZ, ST_LAST, ST_SIN}))
            begin
                done++;
                if (done == count / 2)
                    wait_drained();
            end
            send_event(it);
        end
    endtask

    initial
    begin
        item_t in_beat;
        sb        = new;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PKT_SIZE;
        cfg_data  = '0;
        cur_event = '0;
        burst     = 1'b0;
        out_hold  = 0;
        in_beat   = control_event(KIND_IN_SENT, 0, 0, 0, 0, 0, 0, VERD_FAIL, 0, 0, 0);
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        program_reg(CFG_PKT_SIZE, 9'd64);
        program_reg(CFG_BUF_CAP, 9'd248);

        send_event(control_event(KIND_BUS_RESET, 0, 0, 0, 0, 0, 0, VERD_FAIL, 0, 0, 0));
        // short setup packet
        send_event(control_event(KIND_SETUP, 7, 8'h00, REQ_GET_STATUS, 0, 0, 2,
                                 VERD_FAIL, 0, 0, 0));
        // set address through an OUT in idle, address masked to 7 bits
        send_event(control_event(KIND_OUT, SETUP_LEN, 8'h00, REQ_SET_ADDRESS, 16'h0085, 0, 0,
                                 VERD_FAIL, 0, 0, 0));
        send_event(in_beat);
        send_event(in_beat);
        // long descriptor reply, cursor wraps past 511
        send_event(control_event(KIND_SETUP, SETUP_LEN, 8'h80, REQ_GET_DESCRIPTOR, 16'h0303,
                                 0, 16'd600, VERD_FAIL, 1, 16'd600, 0));
        repeat (10) send_event(in_beat);
        send_event(control_event(KIND_OUT, 3, 0, 0, 0, 0, 0, VERD_FAIL, 0, 0, 0));
        // short reply of a whole packet needs a trailing zero-length packet
        send_event(control_event(KIND_SETUP, SETUP_LEN, 8'hC0, 8'h01, 0, 0, 16'd128,
                                 VERD_ACK, 0, 16'd64, 0));
        send_event(in_beat);
        send_event(in_beat);
        send_event(control_event(KIND_OUT, 0, 0, 0, 0, 0, 0, VERD_FAIL, 0, 0, 0));
        // OUT longer than the bytes left
        send_event(control_event(KIND_SETUP, SETUP_LEN, 8'h21, 8'h09, 0, 0, 16'd10,
                                 VERD_ACK, 0, 0, 0));
        send_event(control_event(KIND_OUT, 11, 0, 0, 0, 0, 0, VERD_ACK, 0, 0, 0));
        // set configuration, then an OUT during status in
        send_event(control_event(KIND_SETUP, SETUP_LEN, 8'h00, REQ_SET_CONFIG, 16'h0103, 0, 0,
                                 VERD_FAIL, 1, 0, 0));
        send_event(control_event(KIND_OUT, 0, 0, 0, 0, 0, 0, VERD_FAIL, 0, 0, 0));
        // nak without data stage
        send_event(control_event(KIND_SETUP, SETUP_LEN, 8'h21, 8'h0A, 0, 0, 0,
                                 VERD_NAK, 0, 0, 0));
        send_event(in_beat);

        run_phase(9'd8, 9'd0, 20);
        run_phase(9'd64, 9'd256, 25);
        // zero packet size: data-in sends zero-length packets without progress
        run_phase(9'd0, 9'd100, 8);
        run_phase(9'd23, 9'd40, 20);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
